// ----- hw/rtl/cfp_pkg.sv -----
// ============================================================================
// Circumcircle package
// Widths, pipeline depths and shared types for the circumcircle datapath.
// ============================================================================
package cfp_pkg;

  // Coordinate width (signed Q12.4).
  localparam int CW    = 16;
  // Width of the determinant d (signed).
  localparam int DW    = 36;
  // Width of the centre numerators nx, ny (signed).
  localparam int NW    = 52;
  // Width of 16 * numerator (signed).
  localparam int NUMW  = NW + 4;
  // Quotient magnitude bits; larger quotients are flagged as too big.
  localparam int QB    = 34;
  // Signed quotient width.
  localparam int QW    = QB + 1;
  // Rounded dividend 2|n| + |d| and doubled divisor 2|d|.
  localparam int NRW   = NUMW + 2;
  localparam int DNW   = DW + 1;
  // Width of the divisor trial compare.
  localparam int CMPW  = DNW + QB + 1;
  // Centre minus first point, signed Q29.8.
  localparam int DXW   = QW + 2;
  // Radius root bits.
  localparam int RB    = 32;

  // Pipeline depths.
  localparam int FR_LAT  = 3;
  localparam int DIV_LAT = QB + 3;
  localparam int RT_LAT  = RB + 4;

  // Saturation limits.
  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;
  localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;

  // Three input points.
  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
  } pts_t;

  // One result word.
  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [31:0]        circle_radius;
    logic               degenerate;
    logic               saturated;
  } res_t;

  // Data that rides beside the dividers.
  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic                 deg;
  } side_div_t;

  // Data that rides beside the square root.
  typedef struct packed {
    logic [31:0] cx;
    logic [31:0] cy;
    logic        satc;
    logic        deg;
  } side_rt_t;

endpackage

// ----- hw/rtl/cfp_in_if.sv -----
// ============================================================================
// Circumcircle input channel
// Valid/ready channel that carries three points per word.
// ============================================================================
interface cfp_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] first_x;
  logic signed [15:0] first_y;
  logic signed [15:0] second_x;
  logic signed [15:0] second_y;
  logic signed [15:0] third_x;
  logic signed [15:0] third_y;

  modport source (
    output valid, first_x, first_y, second_x, second_y, third_x, third_y,
    input  ready
  );
  modport sink (
    input  valid, first_x, first_y, second_x, second_y, third_x, third_y,
    output ready
  );
endinterface

// ----- hw/rtl/cfp_out_if.sv -----
// ============================================================================
// Circumcircle result channel
// Valid/ready channel that carries one circle per word.
// ============================================================================
interface cfp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic [31:0]        circle_radius;
  logic               degenerate;
  logic               saturated;

  modport source (
    output valid, center_x, center_y, circle_radius, degenerate, saturated,
    input  ready
  );
  modport sink (
    input  valid, center_x, center_y, circle_radius, degenerate, saturated,
    output ready
  );
endinterface

// ----- hw/rtl/cfp_front.sv -----
// ============================================================================
// Circumcircle front end
// Three stages that form the determinant d and the centre numerators.
// ============================================================================
module cfp_front
  import cfp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 valid_i,
  input  pts_t                 pts_i,
  output logic                 valid_o,
  output logic signed [DW-1:0] d_o,
  output logic signed [NW-1:0] nx_o,
  output logic signed [NW-1:0] ny_o,
  output logic signed [CW-1:0] ax_o,
  output logic signed [CW-1:0] ay_o
);

  // Stage 1: coordinate differences and squared norms.
  logic signed [CW:0]   dyb, dyc, dya, dxc, dxa, dxb;
  logic signed [31:0]   axx, ayy, bxx, byy, cxx, cyy;
  logic signed [CW:0]   dyb_r, dyc_r, dya_r, dxc_r, dxa_r, dxb_r;
  logic [31:0]          sa_r, sb_r, sc_r;
  pts_t                 p1_r;
  logic                 v1_r;

  assign dyb = $signed({pts_i.by[CW-1], pts_i.by}) - $signed({pts_i.cy[CW-1], pts_i.cy});
  assign dyc = $signed({pts_i.cy[CW-1], pts_i.cy}) - $signed({pts_i.ay[CW-1], pts_i.ay});
  assign dya = $signed({pts_i.ay[CW-1], pts_i.ay}) - $signed({pts_i.by[CW-1], pts_i.by});
  assign dxc = $signed({pts_i.cx[CW-1], pts_i.cx}) - $signed({pts_i.bx[CW-1], pts_i.bx});
  assign dxa = $signed({pts_i.ax[CW-1], pts_i.ax}) - $signed({pts_i.cx[CW-1], pts_i.cx});
  assign dxb = $signed({pts_i.bx[CW-1], pts_i.bx}) - $signed({pts_i.ax[CW-1], pts_i.ax});
  assign axx = pts_i.ax * pts_i.ax;
  assign ayy = pts_i.ay * pts_i.ay;
  assign bxx = pts_i.bx * pts_i.bx;
  assign byy = pts_i.by * pts_i.by;
  assign cxx = pts_i.cx * pts_i.cx;
  assign cyy = pts_i.cy * pts_i.cy;

  always_ff @(posedge clk) begin
    if (en) begin
      dyb_r <= dyb;
      dyc_r <= dyc;
      dya_r <= dya;
      dxc_r <= dxc;
      dxa_r <= dxa;
      dxb_r <= dxb;
      sa_r  <= 32'(axx) + 32'(ayy);
      sb_r  <= 32'(bxx) + 32'(byy);
      sc_r  <= 32'(cxx) + 32'(cyy);
      p1_r  <= pts_i;
    end
  end

  // Stage 2: the nine products.
  logic signed [2*CW:0] pd1_r, pd2_r, pd3_r;
  logic signed [49:0]   px1_r, px2_r, px3_r, py1_r, py2_r, py3_r;
  logic signed [CW-1:0] ax2_r, ay2_r;
  logic                 v2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pd1_r <= p1_r.ax * dyb_r;
      pd2_r <= p1_r.bx * dyc_r;
      pd3_r <= p1_r.cx * dya_r;
      px1_r <= $signed({1'b0, sa_r}) * dyb_r;
      px2_r <= $signed({1'b0, sb_r}) * dyc_r;
      px3_r <= $signed({1'b0, sc_r}) * dya_r;
      py1_r <= $signed({1'b0, sa_r}) * dxc_r;
      py2_r <= $signed({1'b0, sb_r}) * dxa_r;
      py3_r <= $signed({1'b0, sc_r}) * dxb_r;
      ax2_r <= p1_r.ax;
      ay2_r <= p1_r.ay;
    end
  end

  // Stage 3: sums into d, nx and ny.
  logic signed [DW-1:0] dsum;
  logic signed [DW-1:0] d_r;
  logic signed [NW-1:0] nx_r, ny_r;
  logic signed [CW-1:0] ax3_r, ay3_r;
  logic                 v3_r;

  assign dsum = DW'(pd1_r) + DW'(pd2_r) + DW'(pd3_r);

  always_ff @(posedge clk) begin
    if (en) begin
      d_r   <= dsum <<< 1;
      nx_r  <= NW'(px1_r) + NW'(px2_r) + NW'(px3_r);
      ny_r  <= NW'(py1_r) + NW'(py2_r) + NW'(py3_r);
      ax3_r <= ax2_r;
      ay3_r <= ay2_r;
    end
  end

  // Valid bits follow the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign valid_o = v3_r;
  assign d_o     = d_r;
  assign nx_o    = nx_r;
  assign ny_o    = ny_r;
  assign ax_o    = ax3_r;
  assign ay_o    = ay3_r;

endmodule

// ----- hw/rtl/cfp_div.sv -----
// ============================================================================
// Circumcircle divider
// Pipelined restoring divider, one quotient bit per stage, round to nearest.
// ============================================================================
module cfp_div
  import cfp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   valid_i,
  input  logic signed [NUMW-1:0] num_i,
  input  logic signed [DW-1:0]   den_i,
  output logic                   valid_o,
  output logic signed [QW-1:0]   quo_o,
  output logic                   big_o,
  output logic                   neg_o
);

  // Stage A: magnitudes and the quotient sign.
  logic [NUMW-1:0] un_r;
  logic [DW-1:0]   ud_r;
  logic            nega_r, va_r;

  always_ff @(posedge clk) begin
    if (en) begin
      un_r   <= num_i[NUMW-1] ? NUMW'(-num_i) : NUMW'(num_i);
      ud_r   <= den_i[DW-1] ? DW'(-den_i) : DW'(den_i);
      nega_r <= num_i[NUMW-1] ^ den_i[DW-1];
    end
  end

  // Stage B: rounded dividend, doubled divisor and the range check.
  logic [NRW-1:0]  ndiv;
  logic [DNW-1:0]  ddiv;
  logic [NRW-1:0]  rem_r [0:QB];
  logic [DNW-1:0]  den_r [0:QB];
  logic [QB-1:0]   quo_r [0:QB];
  logic            neg_r [0:QB];
  logic            big_r [0:QB];
  logic            vld_r [0:QB];

  assign ndiv = NRW'({un_r, 1'b0}) + NRW'(ud_r);
  assign ddiv = {ud_r, 1'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= ndiv;
      den_r[0] <= ddiv;
      quo_r[0] <= '0;
      neg_r[0] <= nega_r;
      big_r[0] <= CMPW'(ndiv) >= (CMPW'(ddiv) << QB);
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar g = 1; g <= QB; g++) begin : g_bit
    localparam int SH = QB - g;
    logic [CMPW-1:0] trial;
    logic            ge;
    logic [QB-1:0]   quo_nxt;

    assign trial = CMPW'(den_r[g-1]) << SH;
    assign ge    = CMPW'(rem_r[g-1]) >= trial;

    always_comb begin
      quo_nxt     = quo_r[g-1];
      quo_nxt[SH] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= ge ? rem_r[g-1] - NRW'(trial) : rem_r[g-1];
        den_r[g] <= den_r[g-1];
        quo_r[g] <= quo_nxt;
        neg_r[g] <= neg_r[g-1];
        big_r[g] <= big_r[g-1];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vld_r[g-1];
      end
    end
  end

  // Final stage: apply the sign.
  logic signed [QW-1:0] q_r;
  logic                 bigf_r, negf_r, vf_r;

  always_ff @(posedge clk) begin
    if (en) begin
      q_r    <= neg_r[QB] ? -$signed(QW'(quo_r[QB])) : $signed(QW'(quo_r[QB]));
      bigf_r <= big_r[QB];
      negf_r <= neg_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r     <= 1'b0;
      vld_r[0] <= 1'b0;
      vf_r     <= 1'b0;
    end else if (en) begin
      va_r     <= valid_i;
      vld_r[0] <= va_r;
      vf_r     <= vld_r[QB];
    end
  end

  assign valid_o = vf_r;
  assign quo_o   = q_r;
  assign big_o   = bigf_r;
  assign neg_o   = negf_r;

endmodule

// ----- hw/rtl/cfp_root.sv -----
// ============================================================================
// Circumcircle radius unit
// Squares the centre offset and takes a pipelined rounded square root.
// ============================================================================
module cfp_root
  import cfp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  valid_i,
  input  logic signed [DXW-1:0] dx_i,
  input  logic signed [DXW-1:0] dy_i,
  input  logic                  ovf_i,
  output logic                  valid_o,
  output logic [31:0]           rad_o,
  output logic                  sat_o
);

  // Stage 1: magnitudes and range check.
  logic [DXW-1:0] ux, uy;
  logic [31:0]    ux_r, uy_r;
  logic           ovf1_r, v1_r;

  assign ux = dx_i[DXW-1] ? DXW'(-dx_i) : DXW'(dx_i);
  assign uy = dy_i[DXW-1] ? DXW'(-dy_i) : DXW'(dy_i);

  always_ff @(posedge clk) begin
    if (en) begin
      ux_r   <= ux[31:0];
      uy_r   <= uy[31:0];
      ovf1_r <= ovf_i || (ux[DXW-1:32] != '0) || (uy[DXW-1:32] != '0);
    end
  end

  // Stage 2: squares.
  logic [63:0] sqx_r, sqy_r;
  logic        ovf2_r, v2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r  <= 64'(ux_r) * 64'(ux_r);
      sqy_r  <= 64'(uy_r) * 64'(uy_r);
      ovf2_r <= ovf1_r;
    end
  end

  // Stage 3: sum of squares; a carry out means the radius saturates.
  logic [64:0] ssum;
  logic [63:0] rem_r  [0:RB];
  logic [RB-1:0] rt_r [0:RB];
  logic        ovf_r  [0:RB];
  logic        vld_r  [0:RB];

  assign ssum = 65'(sqx_r) + 65'(sqy_r);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= ssum[63:0];
      rt_r[0]  <= '0;
      ovf_r[0] <= ovf2_r || ssum[64];
    end
  end

  // One root bit per stage: keep rem = s - root^2.
  for (genvar g = 1; g <= RB; g++) begin : g_bit
    localparam int SH = RB - g;
    logic [65:0]   term;
    logic          ge;
    logic [RB-1:0] rt_nxt;

    assign term = (66'(rt_r[g-1]) << (SH + 1)) + (66'd1 << (2 * SH));
    assign ge   = 66'(rem_r[g-1]) >= term;

    always_comb begin
      rt_nxt     = rt_r[g-1];
      rt_nxt[SH] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= ge ? rem_r[g-1] - term[63:0] : rem_r[g-1];
        rt_r[g]  <= rt_nxt;
        ovf_r[g] <= ovf_r[g-1];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vld_r[g-1];
      end
    end
  end

  // Final stage: round to nearest and saturate.
  logic [RB:0] rnd;
  logic [31:0] rad_r;
  logic        sat_r, vf_r;

  assign rnd = (rem_r[RB] > 64'(rt_r[RB])) ? (RB+1)'(rt_r[RB]) + 1'b1
                                            : (RB+1)'(rt_r[RB]);

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r <= (ovf_r[RB] || rnd[RB]) ? U32_MAX : rnd[31:0];
      sat_r <= ovf_r[RB] || rnd[RB];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      vld_r[0] <= 1'b0;
      vf_r     <= 1'b0;
    end else if (en) begin
      v1_r     <= valid_i;
      v2_r     <= v1_r;
      vld_r[0] <= v2_r;
      vf_r     <= vld_r[RB];
    end
  end

  assign valid_o = vf_r;
  assign rad_o   = rad_r;
  assign sat_o   = sat_r;

endmodule

// ----- hw/rtl/circle_from_three_points.sv -----
// ============================================================================
// Circumcircle of three points
// Centre (Q24.8) and radius of the circle through three Q12.4 points.
// ============================================================================
// Usage:
//   in_if carries one word of three points; it is taken when valid and
//   ready are both high. out_if returns one word per input word, in order:
//   centre, radius, a degenerate flag for collinear points (all other
//   fields zero) and a saturation flag.
//   From the accepting edge a word passes 3 front stages, 37 divider
//   stages, 1 offset stage and 36 root stages, then the output buffer,
//   before the result word can be taken. A new word can enter in every
//   cycle while in_if.ready is high; the rate is one word per clock unless
//   the receiver stalls, set by the fully pipelined dividers and square root.
//   Reset clears all valid bits and empties the two-word output buffer;
//   payload registers are not reset.
//   When the receiver stalls, the output buffer fills; while it holds two
//   words the whole pipeline freezes and in_if.ready goes low. Nothing is
//   lost or repeated, and ready depends only on registered state.
// ============================================================================
module circle_from_three_points
  import cfp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  cfp_in_if.sink    in_if,
  cfp_out_if.source out_if
);

  logic [1:0] cnt_r;
  logic       en;

  // The pipeline moves whenever the output buffer has a free slot.
  assign en          = (cnt_r != 2'd2);
  assign in_if.ready = en;

  // Front end.
  pts_t                 pts;
  logic                 fr_v;
  logic signed [DW-1:0] fr_d;
  logic signed [NW-1:0] fr_nx, fr_ny;
  logic signed [CW-1:0] fr_ax, fr_ay;

  assign pts = '{ax: in_if.first_x,  ay: in_if.first_y,
                 bx: in_if.second_x, by: in_if.second_y,
                 cx: in_if.third_x,  cy: in_if.third_y};

  cfp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (in_if.valid & en),
    .pts_i   (pts),
    .valid_o (fr_v),
    .d_o     (fr_d),
    .nx_o    (fr_nx),
    .ny_o    (fr_ny),
    .ax_o    (fr_ax),
    .ay_o    (fr_ay)
  );

  // Dividers for both centre coordinates.
  logic                 dvx_v, dvy_v;
  logic signed [QW-1:0] qx, qy;
  logic                 bigx, bigy, negx, negy;

  cfp_div u_div_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (fr_v),
    .num_i   ({fr_nx, 4'b0000}),
    .den_i   (fr_d),
    .valid_o (dvx_v),
    .quo_o   (qx),
    .big_o   (bigx),
    .neg_o   (negx)
  );

  cfp_div u_div_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (fr_v),
    .num_i   ({fr_ny, 4'b0000}),
    .den_i   (fr_d),
    .valid_o (dvy_v),
    .quo_o   (qy),
    .big_o   (bigy),
    .neg_o   (negy)
  );

  // First point and collinear flag ride beside the dividers.
  side_div_t sd_r [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= '{ax: fr_ax, ay: fr_ay, deg: (fr_d == '0)};
      for (int i = 1; i < DIV_LAT; i++) begin
        sd_r[i] <= sd_r[i-1];
      end
    end
  end

  // Offset stage: centre clipping and offset from the first point.
  logic                  clip_x, clip_y;
  logic [31:0]           cx_sat, cy_sat;
  logic signed [DXW-1:0] dx_r, dy_r;
  logic                  ovf_r, tv_r;
  side_rt_t              st_nxt;

  assign clip_x = bigx || !((&qx[QW-1:31]) || (~|qx[QW-1:31]));
  assign clip_y = bigy || !((&qy[QW-1:31]) || (~|qy[QW-1:31]));
  assign cx_sat = clip_x ? ((bigx ? negx : qx[QW-1]) ? S32_MIN : S32_MAX) : qx[31:0];
  assign cy_sat = clip_y ? ((bigy ? negy : qy[QW-1]) ? S32_MIN : S32_MAX) : qy[31:0];
  assign st_nxt = '{cx: cx_sat, cy: cy_sat, satc: clip_x || clip_y,
                    deg: sd_r[DIV_LAT-1].deg};

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r  <= DXW'(qx) - DXW'($signed({sd_r[DIV_LAT-1].ax, 4'b0000}));
      dy_r  <= DXW'(qy) - DXW'($signed({sd_r[DIV_LAT-1].ay, 4'b0000}));
      ovf_r <= bigx || bigy;
    end
  end

  // Radius.
  logic        rt_v, rt_sat;
  logic [31:0] rt_rad;

  cfp_root u_root (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (tv_r),
    .dx_i    (dx_r),
    .dy_i    (dy_r),
    .ovf_i   (ovf_r),
    .valid_o (rt_v),
    .rad_o   (rt_rad),
    .sat_o   (rt_sat)
  );

  // Centre and flags ride beside the root.
  side_rt_t sr_r [0:RT_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= st_nxt;
      for (int i = 1; i <= RT_LAT; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r <= 1'b0;
    end else if (en) begin
      tv_r <= dvx_v & dvy_v;
    end
  end

  // Assemble the result word.
  res_t res;

  always_comb begin
    if (sr_r[RT_LAT].deg) begin
      res = '{center_x: '0, center_y: '0, circle_radius: '0,
              degenerate: 1'b1, saturated: 1'b0};
    end else begin
      res = '{center_x: sr_r[RT_LAT].cx, center_y: sr_r[RT_LAT].cy,
              circle_radius: rt_rad, degenerate: 1'b0,
              saturated: sr_r[RT_LAT].satc | rt_sat};
    end
  end

  // Two-word output buffer.
  res_t fifo_r [0:1];
  logic wr_ptr_r, rd_ptr_r;
  logic push, pop;

  assign push = en & rt_v;
  assign pop  = out_if.valid & out_if.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  assign out_if.valid         = (cnt_r != 2'd0);
  assign out_if.center_x      = fifo_r[rd_ptr_r].center_x;
  assign out_if.center_y      = fifo_r[rd_ptr_r].center_y;
  assign out_if.circle_radius = fifo_r[rd_ptr_r].circle_radius;
  assign out_if.degenerate    = fifo_r[rd_ptr_r].degenerate;
  assign out_if.saturated     = fifo_r[rd_ptr_r].saturated;

endmodule
